// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the sampler RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must never be true while out of reset.
`define ASSERT_NEVER(name, clk_sig, rstn_sig, expr) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) !(expr)) \
        else $error("assertion %m failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("assertion %m failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("assertion %m failed");

`endif

// ===== rtl/core/tps_pkg.sv =====
// Shared types and constants of the texture point sampler.
// Depends on nothing; imported by every sampler module.
package tps_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_SAMPLE       = 2'd0,
        ST_WRITE_DONE   = 2'd1,
        ST_WRITE_REJECT = 2'd2
    } status_t;

    // Operation codes.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Configuration register map.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 9;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TEX_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TEX_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_BITS-1:0]  SIZE_RESET     = 9'd256;

    // Field widths.
    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 16;
    localparam int XY_BITS    = 9;
    localparam int COMP_W     = 16;

    // Input item.
    typedef struct packed {
        logic                         opcode;
        logic signed [COORD_BITS-1:0] u_coord;
        logic signed [COORD_BITS-1:0] v_coord;
        logic [XY_BITS-1:0]           texel_x;
        logic [XY_BITS-1:0]           texel_y;
        logic [COMP_W-1:0]            in_red;
        logic [COMP_W-1:0]            in_green;
        logic [COMP_W-1:0]            in_blue;
        logic [COMP_W-1:0]            in_alpha;
    } in_item_t;

    // Result item.
    typedef struct packed {
        status_t           status;
        logic [COMP_W-1:0] out_red;
        logic [COMP_W-1:0] out_green;
        logic [COMP_W-1:0] out_blue;
        logic [COMP_W-1:0] out_alpha;
    } out_item_t;

    // Command queue flags.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== rtl/core/tps_front.sv =====
// Front end of the sampler: config registers, item intake and classification.
// Depends on tps_pkg; feeds tps_queue with packed commands.
module tps_front
    import tps_pkg::*;
#(
    parameter int MAX_WIDTH      = 256,
    parameter int MAX_HEIGHT     = 256,
    parameter int COMPONENT_BITS = 16,
    parameter int CMD_W          = 150
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  in_item_t                  in_item,
    input  logic                      clearing,
    input  queue_status_t             q_status,
    output logic                      push,
    output logic [CMD_W-1:0]          cmd
);

    localparam int XB  = $clog2(MAX_WIDTH);
    localparam int YB  = $clog2(MAX_HEIGHT);
    localparam int SZX = $clog2(MAX_WIDTH + 1);
    localparam int SZY = $clog2(MAX_HEIGHT + 1);
    localparam int PUW = FRAC_BITS + SZX;
    localparam int PVW = FRAC_BITS + SZY;

    typedef struct packed {
        logic                          is_sample;
        logic                          wr_ok;
        logic [XB-1:0]                 wx;
        logic [YB-1:0]                 wy;
        logic [4*COMPONENT_BITS-1:0]   texel;
        logic [PUW-1:0]                prod_u;
        logic [PVW-1:0]                prod_v;
        logic [SZX-1:0]                wm1;
        logic [SZY-1:0]                hm1;
    } cmd_t;

    logic [CFG_DATA_BITS-1:0] width_reg, width_next;
    logic [CFG_DATA_BITS-1:0] height_reg, height_next;
    logic [SZX-1:0]           w_eff;
    logic [SZY-1:0]           h_eff;
    logic                     f_valid_reg, f_valid_next;
    cmd_t                     f_cmd_reg, f_cmd_next;
    logic                     accept;

    // Configuration writes.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_TEX_WIDTH:  width_next  = cfg_data;
                CFG_TEX_HEIGHT: height_next = cfg_data;
                default:        ;
            endcase
        end
    end

    // Effective sizes: zero reads as one, oversize reads as the maximum.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = SZX'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = SZX'(MAX_WIDTH);
        else
            w_eff = SZX'(width_reg);

        if (height_reg == '0)
            h_eff = SZY'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_eff = SZY'(MAX_HEIGHT);
        else
            h_eff = SZY'(height_reg);
    end

    // Handshake: the staging register drains into the queue.
    assign push     = f_valid_reg && !q_status.full;
    assign in_ready = !clearing && (!f_valid_reg || !q_status.full);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
            f_valid_next = 1'b1;
        else if (push)
            f_valid_next = 1'b0;
        else
            f_valid_next = f_valid_reg;
    end

    // Classify the item and scale the coordinate fractions.
    always_comb
    begin
        logic [31:0]    x_ext;
        logic [31:0]    y_ext;
        logic [PUW-1:0] wm1_ext;
        logic [PVW-1:0] hm1_ext;

        x_ext   = 32'(in_item.texel_x);
        y_ext   = 32'(in_item.texel_y);
        f_cmd_next.wm1 = w_eff - SZX'(1);
        f_cmd_next.hm1 = h_eff - SZY'(1);
        wm1_ext = PUW'(f_cmd_next.wm1);
        hm1_ext = PVW'(f_cmd_next.hm1);

        f_cmd_next.is_sample = (in_item.opcode == OP_SAMPLE);
        f_cmd_next.wr_ok     = (x_ext < 32'(w_eff)) && (y_ext < 32'(h_eff));
        f_cmd_next.wx        = x_ext[XB-1:0];
        f_cmd_next.wy        = y_ext[YB-1:0];
        f_cmd_next.texel     = {in_item.in_alpha[COMP_W-1 -: COMPONENT_BITS],
                                in_item.in_blue[COMP_W-1 -: COMPONENT_BITS],
                                in_item.in_green[COMP_W-1 -: COMPONENT_BITS],
                                in_item.in_red[COMP_W-1 -: COMPONENT_BITS]};
        f_cmd_next.prod_u    = PUW'(in_item.u_coord[FRAC_BITS-1:0]) * wm1_ext;
        f_cmd_next.prod_v    = PVW'(in_item.v_coord[FRAC_BITS-1:0]) * hm1_ext;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= SIZE_RESET;
            height_reg  <= SIZE_RESET;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            f_valid_reg <= f_valid_next;
        end
    end

    // Staged command.
    always_ff @(posedge clk)
    begin
        if (accept)
            f_cmd_reg <= f_cmd_next;
    end

    assign cmd = CMD_W'(f_cmd_reg);

endmodule

// ===== rtl/core/tps_queue.sv =====
// Small command queue between the sampler front and back ends.
// Depends on tps_pkg for the status struct.
module tps_queue
    import tps_pkg::*;
#(
    parameter int WIDTH = 150,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output queue_status_t    status
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/core/tps_back.sv =====
// Back end of the sampler: texel memory, clearing pass, lookup and result register.
// Depends on tps_pkg; consumes commands from tps_queue.
module tps_back
    import tps_pkg::*;
#(
    parameter int MAX_WIDTH      = 256,
    parameter int MAX_HEIGHT     = 256,
    parameter int COMPONENT_BITS = 16,
    parameter int CMD_W          = 150
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  queue_status_t    q_status,
    output logic             pop,
    input  logic [CMD_W-1:0] cmd,
    output logic             clearing,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_item
);

    localparam int XB      = $clog2(MAX_WIDTH);
    localparam int YB      = $clog2(MAX_HEIGHT);
    localparam int SZX     = $clog2(MAX_WIDTH + 1);
    localparam int SZY     = $clog2(MAX_HEIGHT + 1);
    localparam int PUW     = FRAC_BITS + SZX;
    localparam int PVW     = FRAC_BITS + SZY;
    localparam int ADDR_W  = XB + YB;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int TEXEL_W = 4 * COMPONENT_BITS;
    localparam int HALF    = 1 << (FRAC_BITS - 1);

    typedef struct packed {
        logic                          is_sample;
        logic                          wr_ok;
        logic [XB-1:0]                 wx;
        logic [YB-1:0]                 wy;
        logic [4*COMPONENT_BITS-1:0]   texel;
        logic [PUW-1:0]                prod_u;
        logic [PVW-1:0]                prod_v;
        logic [SZX-1:0]                wm1;
        logic [SZY-1:0]                hm1;
    } cmd_t;

    cmd_t                c;
    logic [TEXEL_W-1:0]  mem [DEPTH];
    logic [TEXEL_W-1:0]  rd_data_reg;
    logic                clearing_reg, clearing_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_item_reg, out_item_next;
    logic                out_free;
    logic                m_free;
    logic [XB-1:0]       sx;
    logic [YB-1:0]       sy;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [TEXEL_W-1:0]  mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    assign c = cmd_t'(cmd);

    // Pipeline flow: result register, memory stage, queue head.
    assign out_free = !out_valid_reg || out_ready;
    assign m_free   = !m_valid_reg || out_free;
    assign pop      = !q_status.empty && !clearing_reg && m_free;
    assign clearing = clearing_reg;

    // Round the scaled fractions to the nearest texel and clamp.
    always_comb
    begin
        logic [PUW:0]    scaled_u;
        logic [PVW:0]    scaled_v;
        logic [SZX:0]    idx_u;
        logic [SZY:0]    idx_v;
        logic [SZX-1:0]  cl_u;
        logic [SZY-1:0]  cl_v;
        logic [31:0]     u_ext;
        logic [31:0]     v_ext;

        scaled_u = (PUW + 1)'(c.prod_u) + (PUW + 1)'(HALF);
        scaled_v = (PVW + 1)'(c.prod_v) + (PVW + 1)'(HALF);
        idx_u    = scaled_u[PUW:FRAC_BITS];
        idx_v    = scaled_v[PVW:FRAC_BITS];
        cl_u     = (idx_u > (SZX + 1)'(c.wm1)) ? c.wm1 : idx_u[SZX-1:0];
        cl_v     = (idx_v > (SZY + 1)'(c.hm1)) ? c.hm1 : idx_v[SZY-1:0];
        u_ext    = 32'(cl_u);
        v_ext    = 32'(cl_v);
        sx       = u_ext[XB-1:0];
        sy       = v_ext[YB-1:0];
    end

    // Memory port selection; the clearing pass owns the write port.
    assign mem_we    = clearing_reg || (pop && !c.is_sample && c.wr_ok);
    assign mem_waddr = clearing_reg ? clr_addr_reg : {c.wy, c.wx};
    assign mem_wdata = clearing_reg ? '0 : c.texel;
    assign mem_re    = pop && c.is_sample;
    assign mem_raddr = {sy, sx};

    // Texel memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // Clearing pass after reset, one texel a cycle.
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
                clearing_next = 1'b0;
        end
    end

    // Memory stage status.
    always_comb
    begin
        m_status_next = m_status_reg;
        if (pop)
        begin
            m_valid_next = 1'b1;
            if (c.is_sample)
                m_status_next = ST_SAMPLE;
            else if (c.wr_ok)
                m_status_next = ST_WRITE_DONE;
            else
                m_status_next = ST_WRITE_REJECT;
        end
        else if (out_free)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    // Result register.
    always_comb
    begin
        out_item_next = out_item_reg;
        if (m_valid_reg && out_free)
        begin
            out_valid_next       = 1'b1;
            out_item_next.status = m_status_reg;
            case (m_status_reg)
                ST_SAMPLE:
                begin
                    out_item_next.out_red   = COMP_W'(rd_data_reg[0*COMPONENT_BITS +: COMPONENT_BITS])
                                              << (COMP_W - COMPONENT_BITS);
                    out_item_next.out_green = COMP_W'(rd_data_reg[1*COMPONENT_BITS +: COMPONENT_BITS])
                                              << (COMP_W - COMPONENT_BITS);
                    out_item_next.out_blue  = COMP_W'(rd_data_reg[2*COMPONENT_BITS +: COMPONENT_BITS])
                                              << (COMP_W - COMPONENT_BITS);
                    out_item_next.out_alpha = COMP_W'(rd_data_reg[3*COMPONENT_BITS +: COMPONENT_BITS])
                                              << (COMP_W - COMPONENT_BITS);
                end
                default:
                begin
                    out_item_next.out_red   = '0;
                    out_item_next.out_green = '0;
                    out_item_next.out_blue  = '0;
                    out_item_next.out_alpha = '0;
                end
            endcase
        end
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            m_valid_reg   <= m_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        m_status_reg <= m_status_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== rtl/core/texture_point_sampler.sv =====
// An accepted item passes the front staging register, command queue, memory stage and result
// register. Throughput: one item per cycle while out_ready holds and no clearing pass runs, set
// by the single texel memory access in the back end. Reset clears control state and starts a
// clearing pass over all 2^(XB + YB) texels (65536 by default); in_ready stays low until it ends.
// Configuration writes are taken at any time; both sizes reset to 256.
`include "assert_macros.svh"

module texture_point_sampler
    import tps_pkg::*;
#(
    parameter int MAX_WIDTH      = 256,
    parameter int MAX_HEIGHT     = 256,
    parameter int COMPONENT_BITS = 16,
    parameter int QUEUE_DEPTH    = 4
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  in_item_t                  in_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output out_item_t                 out_item
);

    localparam int XB    = $clog2(MAX_WIDTH);
    localparam int YB    = $clog2(MAX_HEIGHT);
    localparam int SZX   = $clog2(MAX_WIDTH + 1);
    localparam int SZY   = $clog2(MAX_HEIGHT + 1);
    localparam int CMD_W = 2 + XB + YB + 4 * COMPONENT_BITS + 2 * FRAC_BITS
                           + 2 * SZX + 2 * SZY;

    logic             push;
    logic             pop;
    logic             clearing;
    logic [CMD_W-1:0] push_cmd;
    logic [CMD_W-1:0] pop_cmd;
    queue_status_t    q_status;
    logic             out_is_write;
    logic             out_comps_zero;

    // Intake and classification.
    tps_front #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .COMPONENT_BITS (COMPONENT_BITS),
        .CMD_W          (CMD_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .clearing  (clearing),
        .q_status  (q_status),
        .push      (push),
        .cmd       (push_cmd)
    );

    // Decoupling queue.
    tps_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .status    (q_status)
    );

    // Texel memory and result path.
    tps_back #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .COMPONENT_BITS (COMPONENT_BITS),
        .CMD_W          (CMD_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop       (pop),
        .cmd       (pop_cmd),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // A write result on the output carries all-zero components.
    assign out_is_write   = out_valid && (out_item.status != ST_SAMPLE);
    assign out_comps_zero = (out_item.out_red == '0) && (out_item.out_green == '0)
                            && (out_item.out_blue == '0) && (out_item.out_alpha == '0);

    // Checks on the internal flow.
    `ASSERT_NEVER(a_no_accept_while_clearing, clk, rst_n, in_valid && in_ready && clearing)
    `ASSERT_NEVER(a_queue_flags_exclusive, clk, rst_n, q_status.full && q_status.empty)
    `ASSERT_NEXT(a_push_fills_queue, clk, rst_n, push && !pop, !q_status.empty)
    `ASSERT_IMPLIES(a_write_result_zero, clk, rst_n, out_is_write, out_comps_zero)

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the texture point sampler: texel writes, wrapped point samples,
// size registers, random handshake pacing and a predictor of the texel store.
// Depends on tps_pkg and the texture_point_sampler RTL.
`timescale 1ns / 100ps

module tb_top;
    import tps_pkg::*;

    localparam int TEX_MAX_W       = 256;
    localparam int TEX_MAX_H       = 256;
    localparam int COMP_BITS       = 16;
    localparam int STORE_DEPTH     = TEX_MAX_W * TEX_MAX_H;
    localparam int ITEMS_PER_PHASE = 119;
    localparam int NUM_PHASES      = 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int MAX_REPORTS     = 100;
    localparam logic [COMP_W-1:0] COMP_KEEP = 16'hFFFF << (16 - COMP_BITS);

    // Kinds of rows in the directed stimulus.
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SAMPLE,
        ROW_CFG
    } row_kind_t;

    // One directed row: a and b are u/v for samples, x/y for writes, index/value for
    // register writes. Rows marked typed carry their expected status with zero components.
    typedef struct packed {
        row_kind_t   kind;
        logic [23:0] a;
        logic [23:0] b;
        logic [63:0] rgba;
        logic        typed;
        status_t     want;
    } dir_row_t;

    localparam int NUM_ROWS = 24;
    localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
        '{ROW_SAMPLE, 24'h000000, 24'h000000, 64'h0, 1'b1, ST_SAMPLE},
        '{ROW_SAMPLE, 24'h7FFFFF, 24'h800000, 64'h0, 1'b1, ST_SAMPLE},
        '{ROW_WRITE,  24'h000000, 24'h000000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_WRITE_DONE},
        '{ROW_WRITE,  24'h0000FF, 24'h0000FF, 64'h4444_3333_2222_1111, 1'b1, ST_WRITE_DONE},
        '{ROW_WRITE,  24'h000100, 24'h000000, 64'hAAAA_BBBB_CCCC_DDDD, 1'b1, ST_WRITE_REJECT},
        '{ROW_WRITE,  24'h000000, 24'h000100, 64'h1234_5678_9ABC_DEF0, 1'b1, ST_WRITE_REJECT},
        '{ROW_WRITE,  24'h0001FF, 24'h0001FF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_WRITE_REJECT},
        '{ROW_SAMPLE, 24'h000000, 24'h000000, 64'h0, 1'b0, ST_SAMPLE},
        '{ROW_SAMPLE, 24'h00FFFF, 24'h00FFFF, 64'h0, 1'b0, ST_SAMPLE},
        '{ROW_SAMPLE, 24'hFFFFFF, 24'hFFFFFF, 64'h0, 1'b0, ST_SAMPLE},
        '{ROW_WRITE,  24'h000080, 24'h000080, 64'hDEAD_BEEF_0123_4567, 1'b1, ST_WRITE_DONE},
        '{ROW_SAMPLE, 24'h008000, 24'h008000, 64'h0, 1'b0, ST_SAMPLE},
        '{ROW_SAMPLE, 24'h7F8000, 24'h808000, 64'h0, 1'b0, ST_SAMPLE},
        '{ROW_SAMPLE, 24'h007F80, 24'h007F80, 64'h0, 1'b0, ST_SAMPLE},
        '{ROW_WRITE,  24'h0000FF, 24'h000000, 64'hFFFF_0000_FFFF_0000, 1'b1, ST_WRITE_DONE},
        '{ROW_SAMPLE, 24'h00FFFF, 24'h000000, 64'h0, 1'b0, ST_SAMPLE},
        '{ROW_WRITE,  24'h000000, 24'h000000, 64'h0, 1'b1, ST_WRITE_DONE},
        '{ROW_SAMPLE, 24'h000000, 24'h000000, 64'h0, 1'b0, ST_SAMPLE},
        '{ROW_CFG,    24'(CFG_TEX_WIDTH),  24'h000000, 64'h0, 1'b0, ST_SAMPLE},
        '{ROW_CFG,    24'(CFG_TEX_HEIGHT), 24'h0001FF, 64'h0, 1'b0, ST_SAMPLE},
        '{ROW_WRITE,  24'h000000, 24'h0000FF, 64'h5555_6666_7777_8888, 1'b1, ST_WRITE_DONE},
        '{ROW_WRITE,  24'h000001, 24'h000000, 64'h9999_AAAA_BBBB_CCCC, 1'b1, ST_WRITE_REJECT},
        '{ROW_SAMPLE, 24'h00C000, 24'h00FFFF, 64'h0, 1'b0, ST_SAMPLE},
        '{ROW_WRITE,  24'h000000, 24'h000100, 64'h0F0F_F0F0_0F0F_F0F0, 1'b1, ST_WRITE_REJECT}
    };

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    in_item_t                  in_item;
    logic                      out_valid;
    logic                      out_ready;
    out_item_t                 out_item;

    // Predictor state: a copy of the texel store and of the size registers.
    logic [63:0]              texel_mem [0:STORE_DEPTH-1];
    logic [CFG_DATA_BITS-1:0] width_reg;
    logic [CFG_DATA_BITS-1:0] height_reg;

    out_item_t   queued_responses [$];
    int unsigned mismatches  = 0;
    int unsigned burst_left  = 0;
    bit          hold_request = 1'b0;

    texture_point_sampler #(
        .MAX_WIDTH      (TEX_MAX_W),
        .MAX_HEIGHT     (TEX_MAX_H),
        .COMPONENT_BITS (COMP_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #2 clk = ~clk;

    // A size register of zero acts as one; anything above the maximum acts as the maximum.
    function automatic int unsigned eff_size(input logic [CFG_DATA_BITS-1:0] reg_val,
                                             input int unsigned limit);
        if (reg_val == 0)
            return 1;
        if (reg_val > limit)
            return limit;
        return reg_val;
    endfunction

    // Keep the fraction of a Q8.16 coordinate, scale by size - 1, round half up, clamp.
    function automatic int unsigned wrap_pos(input logic [COORD_BITS-1:0] coord,
                                             input int unsigned size);
        int unsigned scaled;
        scaled = coord[FRAC_BITS-1:0] * (size - 1) + (32'd1 << (FRAC_BITS - 1));
        scaled = scaled >> FRAC_BITS;
        if (scaled >= size)
            scaled = size - 1;
        return scaled;
    endfunction

    // Work out the result of one item and apply its effect on the texel store.
    function automatic out_item_t texture_response(input in_item_t it);
        out_item_t   res;
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        logic [63:0] texel;
        w   = eff_size(width_reg, TEX_MAX_W);
        h   = eff_size(height_reg, TEX_MAX_H);
        res = '0;
        if (it.opcode == OP_WRITE)
        begin
            if (it.texel_x < w && it.texel_y < h)
            begin
                texel_mem[it.texel_y * TEX_MAX_W + it.texel_x] =
                    {it.in_alpha & COMP_KEEP, it.in_blue & COMP_KEEP,
                     it.in_green & COMP_KEEP, it.in_red & COMP_KEEP};
                res.status = ST_WRITE_DONE;
            end
            else
            begin
                res.status = ST_WRITE_REJECT;
            end
        end
        else
        begin
            col   = wrap_pos(it.u_coord, w);
            row   = wrap_pos(it.v_coord, h);
            texel = texel_mem[row * TEX_MAX_W + col];
            res.status    = ST_SAMPLE;
            res.out_red   = texel[15:0];
            res.out_green = texel[31:16];
            res.out_blue  = texel[47:32];
            res.out_alpha = texel[63:48];
        end
        return res;
    endfunction

    // Random item: mostly writes inside the texture and samples, some writes anywhere.
    function automatic in_item_t rand_request(input int unsigned w, input int unsigned h);
        in_item_t    it;
        int unsigned pick;
        it.u_coord  = COORD_BITS'($urandom_range(0, 24'hFFFFFF));
        it.v_coord  = COORD_BITS'($urandom_range(0, 24'hFFFFFF));
        it.texel_x  = XY_BITS'($urandom_range(0, 511));
        it.texel_y  = XY_BITS'($urandom_range(0, 511));
        it.in_red   = COMP_W'($urandom_range(0, 65535));
        it.in_green = COMP_W'($urandom_range(0, 65535));
        it.in_blue  = COMP_W'($urandom_range(0, 65535));
        it.in_alpha = COMP_W'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            it.opcode  = OP_WRITE;
            it.texel_x = XY_BITS'($urandom_range(0, w - 1));
            it.texel_y = XY_BITS'($urandom_range(0, h - 1));
        end
        else if (pick < 50)
        begin
            it.opcode = OP_WRITE;
        end
        else
        begin
            it.opcode = OP_SAMPLE;
        end
        return it;
    endfunction

    // Offer one item and hold it until accepted; then queue what it should return.
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        out_item_t predicted;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = texture_response(it);
        queued_responses.push_back(typed ? want : predicted);
    endtask

    // Bursts of back-to-back items separated by random gaps.
    task automatic sender_pace();
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Size registers change only with nothing in flight.
    task automatic set_texture_size(input logic [CFG_INDEX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] value);
        in_valid <= 1'b0;
        while (queued_responses.size() != 0)
            @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == CFG_TEX_WIDTH)
            width_reg = value;
        else if (idx == CFG_TEX_HEIGHT)
            height_reg = value;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Result side: check each accepted item, then choose the next out_ready.
    initial
    begin : result_side
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        out_item_t   want;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (queued_responses.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual %h",
                                 $time, out_item);
                end
                else
                begin
                    want = queued_responses.pop_front();
                    check_field("status", 16'(want.status), 16'(out_item.status));
                    check_field("red", want.out_red, out_item.out_red);
                    check_field("green", want.out_green, out_item.out_green);
                    check_field("blue", want.out_blue, out_item.out_blue);
                    check_field("alpha", want.out_alpha, out_item.out_alpha);
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (mode == 0)
                out_ready <= 1'b1;
            else if (mode == 1)
                out_ready <= ($urandom_range(0, 1) == 1);
            else
                out_ready <= ($urandom_range(0, 9) != 0);
        end
    end

    // Stimulus: reset, directed rows, then random phases under several sizes.
    initial
    begin : stimulus
        in_item_t               it;
        out_item_t              want;
        logic [CFG_DATA_BITS-1:0] new_w;
        logic [CFG_DATA_BITS-1:0] new_h;
        bit                     pace_on;
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        foreach (texel_mem[i])
            texel_mem[i] = '0;
        width_reg  = SIZE_RESET;
        height_reg = SIZE_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows.
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (DIR_ROWS[r].kind == ROW_CFG)
            begin
                set_texture_size(DIR_ROWS[r].a[CFG_INDEX_BITS-1:0],
                                 DIR_ROWS[r].b[CFG_DATA_BITS-1:0]);
            end
            else
            begin
                it.opcode   = (DIR_ROWS[r].kind == ROW_WRITE) ? OP_WRITE : OP_SAMPLE;
                it.u_coord  = DIR_ROWS[r].a;
                it.v_coord  = DIR_ROWS[r].b;
                it.texel_x  = DIR_ROWS[r].a[XY_BITS-1:0];
                it.texel_y  = DIR_ROWS[r].b[XY_BITS-1:0];
                it.in_red   = DIR_ROWS[r].rgba[15:0];
                it.in_green = DIR_ROWS[r].rgba[31:16];
                it.in_blue  = DIR_ROWS[r].rgba[47:32];
                it.in_alpha = DIR_ROWS[r].rgba[63:48];
                want        = '0;
                want.status = DIR_ROWS[r].want;
                sender_pace();
                send_item(it, DIR_ROWS[r].typed, want);
            end
        end

        // Random phases, each under its own pair of sizes.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            pace_on = 1'b1;
            case (p)
                0: begin new_w = 9'd4;   new_h = 9'd4;   end
                1: begin new_w = 9'd511; new_h = 9'd0;   end
                2: begin new_w = 9'd1;   new_h = 9'd256; pace_on = 1'b0; end
                3: begin new_w = 9'd16;  new_h = 9'd8;   pace_on = 1'b0; end
                4:
                begin
                    new_w = CFG_DATA_BITS'($urandom_range(1, 32));
                    new_h = CFG_DATA_BITS'($urandom_range(1, 32));
                end
                5: begin new_w = 9'd257; new_h = 9'd3;   end
                6:
                begin
                    new_w = CFG_DATA_BITS'($urandom_range(0, 511));
                    new_h = CFG_DATA_BITS'($urandom_range(0, 511));
                end
                default: begin new_w = 9'd2; new_h = 9'd2; end
            endcase
            set_texture_size(CFG_TEX_WIDTH, new_w);
            set_texture_size(CFG_TEX_HEIGHT, new_h);
            // Stall the result side for a long stretch while items keep coming.
            if (p == 3)
                hold_request = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Halfway through one phase, let everything drain before going on.
                if (p == 5 && n == ITEMS_PER_PHASE / 2)
                begin
                    in_valid <= 1'b0;
                    while (queued_responses.size() != 0)
                        @(posedge clk);
                    @(posedge clk);
                end
                if (pace_on)
                    sender_pace();
                send_item(rand_request(eff_size(width_reg, TEX_MAX_W),
                                       eff_size(height_reg, TEX_MAX_H)), 1'b0, '0);
            end
        end

        // Drain, then keep the clock running so the pipeline can show any stray result.
        in_valid <= 1'b0;
        while (queued_responses.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog covering the clearing pass after reset and the slowest pacing.
    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
